// ===== rtl/adc_ladder_key_decoder_unit_defines.svh =====
// ---------------------------------------------------------------------------
// Assertion macros for the ladder key decoder
// Each macro expects clk and rst in the scope where it is used.
// ---------------------------------------------------------------------------
`ifndef ADC_LADDER_KEY_DECODER_UNIT_DEFINES_SVH
`define ADC_LADDER_KEY_DECODER_UNIT_DEFINES_SVH

// same-cycle implication, masked during reset
`define ADCLK_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ladder key decoder check failed");

// next-cycle implication, masked during reset
`define ADCLK_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ladder key decoder check failed");

// next-cycle implication that also watches reset itself
`define ADCLK_ASSERT_RST(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("ladder key decoder reset check failed");

`endif

// ===== rtl/adclk_pkg.sv =====
// ---------------------------------------------------------------------------
// adclk_pkg
// Shared widths, register codes and types of the ladder key decoder.
// ---------------------------------------------------------------------------
`default_nettype none

package adclk_pkg;

  localparam int KEYS        = 4;
  localparam int GROUPS      = 4;
  localparam int SAMPLE_BITS = 12;

  localparam int KEY_W     = 3;
  localparam int GRP_W     = 2;
  localparam int TIME_W    = 32;
  localparam int DEB_W     = 16;
  localparam int BOUNDS_W  = 48;
  localparam int MASK_W    = 4;
  localparam int GSEL_W    = 8;
  localparam int CFG_IDX_W = 3;
  localparam int IN_W      = 48;
  localparam int OUT_W     = 8;

  localparam logic [KEY_W-1:0] NO_KEY          = KEY_W'(KEYS);
  localparam logic [DEB_W-1:0] DEFAULT_DEBOUNCE = 16'd50;

  // register indexes of the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_LOW_BOUNDS  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HIGH_BOUNDS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_MASK    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GROUP_SEL   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE    = 3'd4;

  typedef struct packed {
    logic [BOUNDS_W-1:0] low_bounds;
    logic [BOUNDS_W-1:0] high_bounds;
    logic [MASK_W-1:0]   key_mask;
    logic [GSEL_W-1:0]   group_sel;
  } key_cfg_t;

  typedef struct packed {
    logic             hit;
    logic [KEY_W-1:0] key;
  } match_t;

  typedef struct packed {
    logic [KEY_W-1:0]  last_key;
    logic [TIME_W-1:0] last_time;
  } group_entry_t;

endpackage

`default_nettype wire

// ===== rtl/adclk_ram.sv =====
// ---------------------------------------------------------------------------
// adclk_ram
// Generic single-write, single-read RAM with a registered read port.
// ---------------------------------------------------------------------------
`default_nettype none

module adclk_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output      logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ===== rtl/adclk_match.sv =====
// ---------------------------------------------------------------------------
// adclk_match
// Range match: lowest enabled key of the sampled group whose range holds it.
// ---------------------------------------------------------------------------
`default_nettype none

module adclk_match (
  input  wire adclk_pkg::key_cfg_t                      cfg,
  input  wire logic [adclk_pkg::GRP_W-1:0]              group_index,
  input  wire logic [adclk_pkg::SAMPLE_BITS-1:0]        adc_sample,
  output      adclk_pkg::match_t                        result
);
  import adclk_pkg::*;

  logic [KEYS-1:0] key_hit;

  always_comb begin
    logic [SAMPLE_BITS-1:0] lo;
    logic [SAMPLE_BITS-1:0] hi;
    for (int k = 0; k < KEYS; k++) begin
      lo = cfg.low_bounds[k*SAMPLE_BITS +: SAMPLE_BITS];
      hi = cfg.high_bounds[k*SAMPLE_BITS +: SAMPLE_BITS];
      key_hit[k] = cfg.key_mask[k]
                && (cfg.group_sel[2*k +: GRP_W] == group_index)
                && !((lo == '0) && (hi == '0))
                && (adc_sample >= lo) && (adc_sample <= hi);
    end
  end

  // walk down so the lowest matching key wins
  always_comb begin
    result.hit = 1'b0;
    result.key = NO_KEY;
    for (int k = KEYS - 1; k >= 0; k--) begin
      if (key_hit[k]) begin
        result.hit = 1'b1;
        result.key = KEY_W'(k);
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/adc_ladder_key_decoder_unit.sv =====
// ---------------------------------------------------------------------------
// adc_ladder_key_decoder_unit
// Resistor-ladder keypad decoder: per-group last key and last press time in
// a small RAM, read-modify-write per sample with a one-deep write forward.
// ---------------------------------------------------------------------------
//  channel   | dir | beat contents (low bits first)
//  s_axis    | in  | group_index[1:0], adc_sample[13:2], now_ms[45:14]
//  m_axis    | out | press_event[0], pressed_key[3:1], zero pad[7:4]
//  cfg       | in  | cfg_wr_en, cfg_index (register 0..4), cfg_data
//
// One sample per cycle while m_axis does not stall; each result passes the middle
// stage, where the group RAM read issued on acceptance lands, then the compare,
// time subtraction and write-back load it into the output register.
// Reset is synchronous; per-group state is marked invalid in flip-flops and
// reads as no key, time zero until first written. No clearing pass.
// A stalled m_axis holds the output beat and the middle stage, then s_axis.
// ---------------------------------------------------------------------------
`default_nettype none

module adc_ladder_key_decoder_unit #(
  parameter int GROUPS = adclk_pkg::GROUPS
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  input  wire logic                            cfg_wr_en,
  input  wire logic [adclk_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [adclk_pkg::BOUNDS_W-1:0]  cfg_data,
  input  wire logic                            s_axis_tvalid,
  output      logic                            s_axis_tready,
  // group_index[1:0], adc_sample[13:2], now_ms[45:14], zero [47:46]
  input  wire logic [adclk_pkg::IN_W-1:0]      s_axis_tdata,
  output      logic                            m_axis_tvalid,
  input  wire logic                            m_axis_tready,
  // press_event[0], pressed_key[3:1], zero [7:4]
  output      logic [adclk_pkg::OUT_W-1:0]     m_axis_tdata
);
  import adclk_pkg::*;

  localparam int GW    = (GROUPS > 1) ? $clog2(GROUPS) : 1;
  localparam int ENT_W = KEY_W + TIME_W;
  localparam logic [3:0] GROUP_LIMIT = 4'(GROUPS);

  // configuration registers
  key_cfg_t          cfg;
  logic [DEB_W-1:0]  debounce;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg      <= '0;
      debounce <= DEFAULT_DEBOUNCE;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_LOW_BOUNDS:  cfg.low_bounds  <= cfg_data;
        REG_HIGH_BOUNDS: cfg.high_bounds <= cfg_data;
        REG_KEY_MASK:    cfg.key_mask    <= cfg_data[MASK_W-1:0];
        REG_GROUP_SEL:   cfg.group_sel   <= cfg_data[GSEL_W-1:0];
        REG_DEBOUNCE:    debounce        <= cfg_data[DEB_W-1:0];
        default: ;
      endcase
    end
  end

  // input unpack
  logic [GRP_W-1:0]       in_group;
  logic [SAMPLE_BITS-1:0] in_sample;
  logic [TIME_W-1:0]      in_now;
  logic [3:0]             in_group_ext;
  logic                   in_group_ok;
  logic [GW-1:0]          in_addr;
  match_t                 in_match;

  assign in_group     = s_axis_tdata[GRP_W-1:0];
  assign in_sample    = s_axis_tdata[GRP_W +: SAMPLE_BITS];
  assign in_now       = s_axis_tdata[GRP_W+SAMPLE_BITS +: TIME_W];
  assign in_group_ext = {2'b00, in_group};
  assign in_group_ok  = in_group_ext < GROUP_LIMIT;
  assign in_addr      = in_group_ext[GW-1:0];

  adclk_match u_match (
    .cfg         (cfg),
    .group_index (in_group),
    .adc_sample  (in_sample),
    .result      (in_match)
  );

  // handshake
  logic s1_valid;
  logic out_valid;
  logic out_adv;
  logic s1_adv;
  logic in_fire;

  assign out_adv       = !out_valid || m_axis_tready;
  assign s1_adv        = s1_valid && out_adv;
  assign s_axis_tready = !s1_valid || out_adv;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  // group state RAM
  logic [GROUPS-1:0] ent_valid;
  logic              ram_we;
  logic [GW-1:0]     ram_waddr;
  group_entry_t      ram_wdata;
  logic [ENT_W-1:0]  ram_rdata;

  adclk_ram #(
    .WIDTH (ENT_W),
    .DEPTH (GROUPS)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_fire),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  // middle stage: the RAM read is in flight
  logic              s1_group_ok;
  logic [GW-1:0]     s1_addr;
  logic [KEY_W-1:0]  s1_key;
  logic [TIME_W-1:0] s1_now;
  logic              s1_ent_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_group_ok  <= in_group_ok;
      s1_addr      <= in_addr;
      s1_key       <= in_match.hit ? in_match.key : NO_KEY;
      s1_now       <= in_now;
      s1_ent_valid <= ent_valid[in_addr];
    end
  end

  // last write, forwarded over the read that raced it
  logic         fwd_valid;
  logic [GW-1:0] fwd_addr;
  group_entry_t fwd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_valid <= 1'b0;
      ent_valid <= '0;
    end else if (ram_we) begin
      fwd_valid            <= 1'b1;
      ent_valid[ram_waddr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      fwd_addr <= ram_waddr;
      fwd_data <= ram_wdata;
    end
  end

  group_entry_t      cur;
  logic [DEB_W-1:0]  deb_eff;
  logic [TIME_W-1:0] elapsed;
  logic              press;

  always_comb begin
    if (fwd_valid && (fwd_addr == s1_addr)) begin
      cur = fwd_data;
    end else if (s1_ent_valid) begin
      cur = group_entry_t'(ram_rdata);
    end else begin
      cur.last_key  = NO_KEY;
      cur.last_time = '0;
    end
  end

  assign deb_eff = (debounce == '0) ? DEFAULT_DEBOUNCE : debounce;
  assign elapsed = s1_now - cur.last_time;
  assign press   = s1_group_ok && (s1_key != cur.last_key) && (s1_key != NO_KEY)
                && (elapsed >= {{(TIME_W-DEB_W){1'b0}}, deb_eff});

  assign ram_we              = s1_adv && s1_group_ok;
  assign ram_waddr           = s1_addr;
  assign ram_wdata.last_key  = s1_key;
  assign ram_wdata.last_time = press ? s1_now : cur.last_time;

  // output register
  logic             out_press;
  logic [KEY_W-1:0] out_key;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_adv) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_press <= press;
      out_key   <= press ? s1_key : NO_KEY;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {{(OUT_W-KEY_W-1){1'b0}}, out_key, out_press};

endmodule

`default_nettype wire

// ===== rtl/adclk_checker.sv =====
// ---------------------------------------------------------------------------
// adclk_checker
// Port-level checks of the ladder key decoder, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

`include "adc_ladder_key_decoder_unit_defines.svh"

module adclk_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        s_axis_tvalid,
  input wire logic                        s_axis_tready,
  input wire logic                        m_axis_tvalid,
  input wire logic                        m_axis_tready,
  input wire logic [adclk_pkg::OUT_W-1:0] m_axis_tdata
);
  import adclk_pkg::*;

  // no beat may come out right after reset
  `ADCLK_ASSERT_RST(a_idle_after_reset, rst, !m_axis_tvalid)
  // a stalled beat holds
  `ADCLK_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))
  // a press names a real key, a non-press names none
  `ADCLK_ASSERT_NOW(a_key_code, m_axis_tvalid, (m_axis_tdata[0] && (m_axis_tdata[3:1] < NO_KEY)) || (!m_axis_tdata[0] && (m_axis_tdata[3:1] == NO_KEY)))
  // a free output side never blocks the input
  `ADCLK_ASSERT_NOW(a_ready_when_drained, !m_axis_tvalid && s_axis_tvalid, s_axis_tready)

endmodule

bind adc_ladder_key_decoder_unit adclk_checker u_adclk_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
